// ===== src/cau_pkg.sv =====
// Shared types, operation codes and saturation helper for the complex ALU.
`default_nettype none
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int DW        = 2 * WORD_BITS;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [2:0] req_type;
    word_t      a_re;
    word_t      a_im;
    word_t      b_re;
    word_t      b_im;
  } in_word_t;

  typedef struct packed {
    word_t res_re;
    word_t res_im;
    logic  equal_flag;
    logic  div_zero_flag;
    logic  overflow_flag;
  } out_word_t;

  // Per-item control carried alongside the divider
  typedef struct packed {
    logic      is_div;
    logic      re_neg;
    logic      im_neg;
    out_word_t pre;
  } side_t;

  // Sign-magnitude to saturated word; top bit is the overflow flag.
  function automatic logic [WORD_BITS:0] sat_word(input logic neg,
                                                  input logic [DW-1:0] mag);
    logic [DW-1:0]        limit;
    logic [WORD_BITS-1:0] v;
    limit = DW'(1) << (WORD_BITS - 1);
    if (!neg) limit = limit - DW'(1);
    v = mag[WORD_BITS-1:0];
    if (mag > limit) return {1'b1, neg ? WORD_MIN : WORD_MAX};
    return {1'b0, neg ? (~v + {{(WORD_BITS-1){1'b0}}, 1'b1}) : v};
  endfunction

endpackage
`default_nettype wire

// ===== src/cau_front.sv =====
// Front pipeline: products, sums, sign-magnitude and non-divide results.
`default_nettype none
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire in_word_t      in_word,
  output logic               f_valid,
  output side_t              f_side,
  output logic [DW-1:0]      f_num_re,
  output logic [DW-1:0]      f_num_im,
  output logic [DW-1:0]      f_den
);

  // stage 1
  logic                    v1_r;
  logic [2:0]              op1_r;
  logic signed [DW-1:0]    p_ac_r, p_bd_r, p_ad_r, p_bc_r, p_cc_r, p_dd_r;
  logic signed [WORD_BITS:0] s_re_r, s_im_r;
  logic                    eq1_r, dz1_r;
  logic signed [WORD_BITS:0] s_re_nxt, s_im_nxt;

  always_comb begin
    if (in_word.req_type == OP_SUB) begin
      s_re_nxt = (WORD_BITS+1)'(in_word.a_re) - (WORD_BITS+1)'(in_word.b_re);
      s_im_nxt = (WORD_BITS+1)'(in_word.a_im) - (WORD_BITS+1)'(in_word.b_im);
    end else begin
      s_re_nxt = (WORD_BITS+1)'(in_word.a_re) + (WORD_BITS+1)'(in_word.b_re);
      s_im_nxt = (WORD_BITS+1)'(in_word.a_im) + (WORD_BITS+1)'(in_word.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      op1_r  <= in_word.req_type;
      p_ac_r <= DW'(in_word.a_re) * DW'(in_word.b_re);
      p_bd_r <= DW'(in_word.a_im) * DW'(in_word.b_im);
      p_ad_r <= DW'(in_word.a_re) * DW'(in_word.b_im);
      p_bc_r <= DW'(in_word.a_im) * DW'(in_word.b_re);
      p_cc_r <= DW'(in_word.b_re) * DW'(in_word.b_re);
      p_dd_r <= DW'(in_word.b_im) * DW'(in_word.b_im);
      s_re_r <= s_re_nxt;
      s_im_r <= s_im_nxt;
      eq1_r  <= (in_word.req_type == OP_CMP) && (in_word.a_re == in_word.b_re) &&
                (in_word.a_im == in_word.b_im);
      dz1_r  <= (in_word.req_type == OP_DIV) && (in_word.b_re == '0) &&
                (in_word.b_im == '0);
    end
  end

  // stage 2: combine products for the selected operation, or pass the sums on
  logic                 v2_r;
  logic [2:0]           op2_r;
  logic signed [DW:0]   x_re_r, x_im_r;
  logic [DW-1:0]        den2_r;
  logic                 eq2_r, dz2_r;
  logic signed [DW:0]   x_re_nxt, x_im_nxt;

  always_comb begin
    case (op1_r)
      OP_MUL: begin
        x_re_nxt = (DW+1)'(p_ac_r) - (DW+1)'(p_bd_r);
        x_im_nxt = (DW+1)'(p_ad_r) + (DW+1)'(p_bc_r);
      end
      OP_DIV: begin
        x_re_nxt = (DW+1)'(p_ac_r) + (DW+1)'(p_bd_r);
        x_im_nxt = (DW+1)'(p_bc_r) - (DW+1)'(p_ad_r);
      end
      default: begin
        x_re_nxt = (DW+1)'(s_re_r);
        x_im_nxt = (DW+1)'(s_im_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      op2_r  <= op1_r;
      x_re_r <= x_re_nxt;
      x_im_r <= x_im_nxt;
      den2_r <= $unsigned(p_cc_r) + $unsigned(p_dd_r);
      eq2_r  <= eq1_r;
      dz2_r  <= dz1_r;
    end
  end

  // stage 3: magnitudes, truncation and saturation for the quick ops
  logic               re_neg, im_neg;
  logic [DW:0]        re_full, im_full;
  logic [DW-1:0]      re_mag, im_mag, re_sh, im_sh;
  logic [WORD_BITS:0] re_sat, im_sat;
  side_t              side_nxt;

  always_comb begin
    re_neg  = x_re_r[DW];
    im_neg  = x_im_r[DW];
    re_full = re_neg ? -x_re_r : x_re_r;
    im_full = im_neg ? -x_im_r : x_im_r;
    re_mag  = re_full[DW-1:0];
    im_mag  = im_full[DW-1:0];
    re_sh   = (op2_r == OP_MUL) ? (re_mag >> FRAC_BITS) : re_mag;
    im_sh   = (op2_r == OP_MUL) ? (im_mag >> FRAC_BITS) : im_mag;
    re_sat  = sat_word(re_neg, re_sh);
    im_sat  = sat_word(im_neg, im_sh);
    side_nxt        = '0;
    side_nxt.re_neg = re_neg;
    side_nxt.im_neg = im_neg;
    case (op2_r)
      OP_ADD, OP_SUB, OP_MUL: begin
        side_nxt.pre.res_re        = re_sat[WORD_BITS-1:0];
        side_nxt.pre.res_im        = im_sat[WORD_BITS-1:0];
        side_nxt.pre.overflow_flag = re_sat[WORD_BITS] | im_sat[WORD_BITS];
      end
      OP_DIV: begin
        side_nxt.pre.div_zero_flag = dz2_r;
        side_nxt.is_div            = !dz2_r;
      end
      OP_CMP: begin
        side_nxt.pre.equal_flag = eq2_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= v2_r;
    end
    if (en) begin
      f_side   <= side_nxt;
      f_num_re <= re_mag;
      f_num_im <= im_mag;
      f_den    <= den2_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/cau_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
`default_nettype none
module cau_div import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DW-1:0]     num,
  input  wire logic [DW-1:0]     den,
  output logic                   big,
  output logic [WORD_BITS:0]     quo
);

  localparam int NW    = DW + FRAC_BITS;
  localparam int QB    = WORD_BITS + 1;

  logic [NW-1:0] n_ext;
  logic [NW-1:0] n_top;

  logic [DW:0]   rem_r [0:QB];
  logic [QB-1:0] nlo_r [0:QB];
  logic [QB-1:0] q_r   [0:QB];
  logic [DW-1:0] den_r [0:QB];
  logic          big_r [0:QB];

  always_comb begin
    n_ext = {num, {FRAC_BITS{1'b0}}};
    n_top = n_ext >> QB;
  end

  // entry: quotient at or above 2^QB saturates outright
  always_ff @(posedge clk) begin
    if (en) begin
      big_r[0] <= n_top >= NW'(den);
      rem_r[0] <= n_top[DW:0];
      nlo_r[0] <= n_ext[QB-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] rs;
    logic        ge;
    always_comb begin
      rs = {rem_r[k][DW-1:0], nlo_r[k][QB-1]};
      ge = rs >= {1'b0, den_r[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? (rs - {1'b0, den_r[k]}) : rs;
        nlo_r[k+1] <= nlo_r[k] << 1;
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        den_r[k+1] <= den_r[k];
        big_r[k+1] <= big_r[k];
      end
    end
  end

  assign big = big_r[QB];
  assign quo = q_r[QB];

endmodule
`default_nettype wire

// ===== src/complex_arithmetic_unit_core.sv =====
// Top level of the pipelined complex ALU.
//
//  channel | direction | handshake           | word
//  in_     | input     | in_valid / in_stall | in_word_t  (op, a, b)
//  out_    | output    | out_valid/out_stall | out_word_t (result, flags)
//
// One word per cycle while the output is not stalled; the divider retires one
// quotient bit per stage.
// Synchronous active-low reset clears every valid bit; payload is not reset.
// A stall on the output while a result is held freezes the whole pipeline and raises in_stall.
`default_nettype none
module complex_arithmetic_unit_core import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word
);

  localparam int DLAT = WORD_BITS + 2;

  logic          en;
  logic          f_valid;
  side_t         f_side;
  logic [DW-1:0] f_num_re, f_num_im, f_den;
  logic          big_re, big_im;
  logic [WORD_BITS:0] q_re, q_im;

  logic          out_valid_r;
  out_word_t     out_word_r;

  // advance unless a held result is blocked
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_word  (in_word),
    .f_valid  (f_valid),
    .f_side   (f_side),
    .f_num_re (f_num_re),
    .f_num_im (f_num_im),
    .f_den    (f_den)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk (clk),
    .en  (en),
    .num (f_num_re),
    .den (f_den),
    .big (big_re),
    .quo (q_re)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk (clk),
    .en  (en),
    .num (f_num_im),
    .den (f_den),
    .big (big_im),
    .quo (q_im)
  );

  // side line matching divider latency
  logic  dv_r   [0:DLAT-1];
  side_t dside_r[0:DLAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= f_valid;
    end
    if (en) begin
      dside_r[0] <= f_side;
    end
  end

  for (genvar k = 1; k < DLAT; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= dv_r[k-1];
      end
      if (en) begin
        dside_r[k] <= dside_r[k-1];
      end
    end
  end

  side_t              last;
  logic [DW-1:0]      mre, mim;
  logic [WORD_BITS:0] sre, sim;
  out_word_t          out_word_nxt;

  always_comb begin
    last = dside_r[DLAT-1];
    mre  = big_re ? '1 : DW'(q_re);
    mim  = big_im ? '1 : DW'(q_im);
    sre  = sat_word(last.re_neg, mre);
    sim  = sat_word(last.im_neg, mim);
    out_word_nxt = last.pre;
    if (last.is_div) begin
      out_word_nxt.res_re        = sre[WORD_BITS-1:0];
      out_word_nxt.res_im        = sim[WORD_BITS-1:0];
      out_word_nxt.overflow_flag = sre[WORD_BITS] | sim[WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[DLAT-1];
    end
    if (en) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the pipelined complex ALU, scoreboard and drivers.
`timescale 1ns / 1ps
module testbench;
  import cau_pkg::*;

  localparam int FRAC = 16;
  localparam int RANDOM_WORDS = 1950;
  localparam int DRAIN_CYCLES = 100;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      quiet;
  logic      drained;

  complex_arithmetic_unit_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  class alu_scoreboard;
    out_word_t pending[$];
    int errors = 0;

    task report(input string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Saturate a sign-magnitude value to one word.
    function automatic word_t clamp(input logic neg, input logic [127:0] mag,
                                    inout logic ovf);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (mag > lim) begin
        ovf = 1'b1;
        return neg ? WORD_MIN : WORD_MAX;
      end
      return neg ? word_t'(-mag[31:0]) : word_t'(mag[31:0]);
    endfunction

    function automatic word_t trunc_part(input logic signed [127:0] v, inout logic ovf);
      logic [127:0] mag;
      mag = v < 0 ? -v : v;
      return clamp(v < 0, mag >> FRAC, ovf);
    endfunction

    function automatic word_t quot_part(input logic signed [127:0] num,
                                        input logic [127:0] den, inout logic ovf);
      logic [127:0] mag;
      mag = num < 0 ? -num : num;
      return clamp(num < 0, (mag << FRAC) / den, ovf);
    endfunction

    function automatic out_word_t compute(input in_word_t w);
      out_word_t r;
      logic signed [127:0] ar, ai, br, bi;
      logic [127:0] den;
      logic ovf;
      r = '0;
      ovf = 1'b0;
      ar = 128'(w.a_re);
      ai = 128'(w.a_im);
      br = 128'(w.b_re);
      bi = 128'(w.b_im);
      case (w.req_type)
        OP_ADD: begin
          r.res_re = clamp(ar + br < 0, (ar + br < 0) ? -(ar + br) : ar + br, ovf);
          r.res_im = clamp(ai + bi < 0, (ai + bi < 0) ? -(ai + bi) : ai + bi, ovf);
        end
        OP_SUB: begin
          r.res_re = clamp(ar - br < 0, (ar - br < 0) ? -(ar - br) : ar - br, ovf);
          r.res_im = clamp(ai - bi < 0, (ai - bi < 0) ? -(ai - bi) : ai - bi, ovf);
        end
        OP_MUL: begin
          r.res_re = trunc_part(ar * br - ai * bi, ovf);
          r.res_im = trunc_part(ar * bi + ai * br, ovf);
        end
        OP_DIV: begin
          if (w.b_re == 0 && w.b_im == 0) begin
            r.div_zero_flag = 1'b1;
          end else begin
            den = br * br + bi * bi;
            r.res_re = quot_part(ar * br + ai * bi, den, ovf);
            r.res_im = quot_part(ai * br - ar * bi, den, ovf);
          end
        end
        OP_CMP: r.equal_flag = (w.a_re == w.b_re) && (w.a_im == w.b_im);
        default: ;
      endcase
      r.overflow_flag = ovf;
      return r;
    endfunction

    function void note(input in_word_t w);
      pending.push_back(compute(w));
    endfunction

    task check(input out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.res_re !== want.res_re)
        report($sformatf("res_re got %h want %h", got.res_re, want.res_re));
      if (got.res_im !== want.res_im)
        report($sformatf("res_im got %h want %h", got.res_im, want.res_im));
      if (got.equal_flag !== want.equal_flag)
        report($sformatf("equal_flag got %b want %b", got.equal_flag, want.equal_flag));
      if (got.div_zero_flag !== want.div_zero_flag)
        report($sformatf("div_zero_flag got %b want %b",
                         got.div_zero_flag, want.div_zero_flag));
      if (got.overflow_flag !== want.overflow_flag)
        report($sformatf("overflow_flag got %b want %b",
                         got.overflow_flag, want.overflow_flag));
    endtask
  endclass

  alu_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int pause();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  task send(input in_word_t w);
    int gap;
    gap = pause();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (in_stall);
    sb.note(w);
    @(negedge clk);
  endtask

  function automatic word_t pick_part(input int kind);
    case (kind)
      0: return word_t'($urandom());
      1: return word_t'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      2: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      default: return word_t'($urandom_range(0, 4)) - 2;
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int kind;
    kind = $urandom_range(0, 9);
    kind = kind < 4 ? 0 : kind < 8 ? 1 : kind < 9 ? 2 : 3;
    w.req_type = $urandom_range(0, 19) == 0 ? 3'($urandom_range(OP_CMP + 1, 7))
                                            : 3'($urandom_range(OP_ADD, OP_CMP));
    w.a_re = pick_part(kind);
    w.a_im = pick_part(kind);
    w.b_re = pick_part($urandom_range(0, 3));
    w.b_im = pick_part($urandom_range(0, 3));
    // hit divide by zero and equal operands now and then
    if ($urandom_range(0, 7) == 0) begin
      if (w.req_type == OP_DIV) begin
        w.b_re = '0;
        w.b_im = '0;
      end else begin
        w.b_re = w.a_re;
        w.b_im = $urandom_range(0, 1) ? w.a_im : w.a_im ^ word_t'(1);
      end
    end
    return w;
  endfunction

  function automatic in_word_t mk(input logic [2:0] op, input word_t ar, input word_t ai,
                                  input word_t br, input word_t bi);
    in_word_t w;
    w.req_type = op;
    w.a_re = ar;
    w.a_im = ai;
    w.b_re = br;
    w.b_im = bi;
    return w;
  endfunction

  // Result side: random stall per word, monitor at the rising edge.
  initial begin
    int n;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = pause();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_word);
  end

  initial begin
    int k;
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send(mk(OP_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
    send(mk(OP_ADD, 32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, 32'sh0000_0001));
    send(mk(OP_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN));
    send(mk(OP_SUB, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0003_0000));
    send(mk(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send(mk(OP_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN));
    send(mk(OP_MUL, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0004_0000));
    send(mk(OP_MUL, -32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001));
    send(mk(OP_DIV, 32'sh0001_0000, 32'sh0001_0000, '0, '0));
    send(mk(OP_DIV, WORD_MAX, WORD_MIN, '0, '0));
    send(mk(OP_DIV, WORD_MAX, WORD_MAX, 32'sh0000_0001, '0));
    send(mk(OP_DIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send(mk(OP_DIV, 32'sh0004_0000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000));
    send(mk(OP_DIV, -32'sh0000_0003, 32'sh0000_0007, WORD_MAX, WORD_MIN));
    send(mk(OP_CMP, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
    send(mk(OP_CMP, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN));
    send(mk(OP_CMP, '0, '0, '0, '0));
    send(mk(OP_CMP + 3'd1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    send(mk(3'd6, WORD_MIN, 32'sh1234_5678, '0, '0));
    send(mk(3'd7, -32'sh0000_0001, -32'sh0000_0001, '0, '0));

    for (k = 0; k < RANDOM_WORDS; k++) begin
      // switch at random between stretches with and without idling
      if (k % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      send(random_word());
    end
    in_valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    drained = (sb.pending.size() == 0);
    if (!drained) sb.report("expected word never arrived");
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
